[rtl/core/ttrc_pkg.sv]
`timescale 1ns / 1ps

package ttrc_pkg;

   // Field widths
   localparam int unsigned DATA_W = 8;
   localparam int unsigned TERM_W = 16;
   localparam int unsigned POS_W  = 8;
   localparam int unsigned PROD_W = 25;   // (9-bit sum) * (16-bit term)

   // Recurrence constants
   localparam logic [TERM_W-1:0] CK_MODULUS   = 16'hFFFF;
   localparam logic [POS_W-1:0]  ALPHA_STEP   = 8'd17;
   localparam logic [POS_W-1:0]  BETA_STEP    = 8'd31;
   localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
   localparam logic [TERM_W-1:0] TERM_RESET   = 16'd1;

   typedef logic [TERM_W-1:0] term_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [POS_W-1:0]  pos_type;

   // Residue mod 65535 of a product by two end-around folds
   function automatic term_type mod_m(input logic [PROD_W-1:0] x);
      logic [TERM_W:0]   fold1;
      logic [TERM_W-1:0] fold2;
      fold1 = {1'b0, x[TERM_W-1:0]} + {{(2*TERM_W-PROD_W+1){1'b0}}, x[PROD_W-1:TERM_W]};
      fold2 = fold1[TERM_W-1:0] + {{(TERM_W-1){1'b0}}, fold1[TERM_W]};
      if (fold2 == CK_MODULUS) begin
         fold2 = '0;
      end
      return fold2;
   endfunction

endpackage

[rtl/core/three_term_recurrence_checksum_top.sv]
`timescale 1ns / 1ps

// Channel | Dir | Ports                                  | Transaction
// req     | in  | req_valid/ready, data_byte, last_byte  | one message byte
// rsp     | out | rsp_valid/ready, checksum_value        | one checksum per message
//
// One byte per cycle unless a last byte waits in stage 1 for a held checksum; a checksum is registered
// in the output register when its last byte leaves stage 1. Stage 1 registers the byte; stage 2 runs both
// multiplies and the mod 65535 reduction combinationally and updates the term registers, which closes the recurrence.
// Synchronous active-high reset clears both stages and rearms for a new message.
// A stalled rsp holds only a last byte in stage 1; other bytes keep flowing.
module three_term_recurrence_checksum_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ttrc_pkg::data_type    req_data_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ttrc_pkg::term_type    rsp_checksum_value
);
   import ttrc_pkg::*;

   // Stage 1 input register
   logic     s1_valid_ff, s1_valid_in;
   data_type s1_byte_ff;
   logic     s1_last_ff;
   logic     s1_advance;

   // Recurrence state
   term_type term_prev_ff, term_prev_in;
   term_type term_cur_ff, term_cur_in;
   pos_type  byte_pos_ff, byte_pos_in;
   logic     msg_start_ff, msg_start_in;

   // Output register
   logic     rsp_valid_ff, rsp_valid_in;
   term_type rsp_value_ff;

   // Datapath
   pos_type             alpha, beta;
   logic [DATA_W:0]     byte_sum;
   logic [PROD_W-1:0]   prod, sub;
   term_type            p_res, s_res, p_adj, next_term;
   logic                wrapped;
   logic [TERM_W:0]     diff;

   // A last byte waits in stage 1 while the previous checksum is still held
   assign s1_advance  = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // next = ((byte+alpha)*cur - beta*prev) mod 65535, with 2^64 = 1 on wrap
   always_comb begin
      alpha    = POS_W'(byte_pos_ff * ALPHA_STEP);
      beta     = POS_W'(byte_pos_ff * BETA_STEP);
      byte_sum = {1'b0, s1_byte_ff} + {1'b0, alpha};
      prod     = PROD_W'(byte_sum) * PROD_W'(term_cur_ff);
      sub      = PROD_W'(beta) * PROD_W'(term_prev_ff);
      wrapped  = prod < sub;
      p_res    = mod_m(prod);
      s_res    = mod_m(sub);
      p_adj    = p_res + TERM_W'(wrapped);
      if (p_adj == CK_MODULUS) begin
         p_adj = '0;
      end
      if (p_adj >= s_res) begin
         diff = {1'b0, p_adj} - {1'b0, s_res};
      end else begin
         diff = {1'b0, p_adj} + {1'b0, CK_MODULUS} - {1'b0, s_res};
      end
      next_term = diff[TERM_W-1:0];
   end

   // State update and rearm after the last byte
   always_comb begin
      term_prev_in = term_prev_ff;
      term_cur_in  = term_cur_ff;
      byte_pos_in  = byte_pos_ff;
      msg_start_in = msg_start_ff;
      if (s1_advance) begin
         if (s1_last_ff) begin
            term_prev_in = TERM_RESET;
            term_cur_in  = TERM_RESET;
            byte_pos_in  = '0;
            msg_start_in = 1'b1;
         end else if (msg_start_ff) begin
            term_prev_in = TERM_RESET;
            term_cur_in  = TERM_W'(s1_byte_ff) + FIRST_OFFSET;
            byte_pos_in  = POS_W'(1);
            msg_start_in = 1'b0;
         end else begin
            term_prev_in = term_cur_ff;
            term_cur_in  = next_term;
            byte_pos_in  = byte_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_prev_ff <= TERM_RESET;
         term_cur_ff  <= TERM_RESET;
         byte_pos_ff  <= '0;
         msg_start_ff <= 1'b1;
      end else begin
         term_prev_ff <= term_prev_in;
         term_cur_ff  <= term_cur_in;
         byte_pos_ff  <= byte_pos_in;
         msg_start_ff <= msg_start_in;
      end
   end

   // Output register
   assign rsp_valid_in = (s1_advance && s1_last_ff) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_advance && s1_last_ff) begin
         rsp_value_ff <= msg_start_ff ? (TERM_W'(s1_byte_ff) + FIRST_OFFSET) : next_term;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_checksum_value = rsp_value_ff;

endmodule

[rtl/core/ttrc_checker.sv]
`timescale 1ns / 1ps

module ttrc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last_byte,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ttrc_pkg::term_type rsp_checksum_value
);
   import ttrc_pkg::*;

   // A held checksum stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum_value))
      else $error("rsp transaction changed while stalled");

   // Checksum is a residue mod 65535
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_checksum_value != CK_MODULUS)
      else $error("checksum out of range");

   // A rising rsp_valid only follows an accepted last byte
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_byte, 2))
      else $error("checksum without a last byte");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Input side drains when the output is free
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !reset && $past(!reset) |-> req_ready)
      else $error("req stalled with idle output");

endmodule

bind three_term_recurrence_checksum_top ttrc_checker u_ttrc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_last_byte      (req_last_byte),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_checksum_value (rsp_checksum_value)
);

[sim/tb_three_term_recurrence_checksum_top.sv]
`timescale 1ns / 1ps

module tb_three_term_recurrence_checksum_top;
   import ttrc_pkg::*;

   localparam int unsigned STALL_LIMIT = 3000;   // cycles with no transaction on either side
   localparam int unsigned TAIL_CYCLES = 10;     // idle cycles run after all checksums drain

   logic     clock              = 1'b0;
   logic     reset              = 1'b1;
   logic     req_valid          = 1'b0;
   logic     req_ready;
   data_type req_data_byte      = '0;
   logic     req_last_byte      = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready          = 1'b0;
   term_type rsp_checksum_value;

   // Checksum predictor state
   term_type sum_prev_term;
   term_type sum_cur_term;
   pos_type  sum_position;
   logic     sum_at_start;
   term_type pending_checksums[$];

   int unsigned fail_count    = 0;
   int unsigned idle_cycles   = 0;
   int unsigned burst_left    = 0;
   int unsigned hold_off_left = 0;
   logic        gaps_on       = 1'b0;
   logic        stalls_on     = 1'b0;
   logic [15:0] ready_pattern = 16'hFFFF;
   logic [3:0]  pattern_idx   = '0;

   three_term_recurrence_checksum_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_checksum_value (rsp_checksum_value)
   );

   always #4 clock = ~clock;

   // One recurrence step; the difference wraps as a 64-bit unsigned value
   function automatic term_type next_term(data_type b, pos_type pos, term_type cur,
                                          term_type prev);
      pos_type     alpha;
      pos_type     beta;
      logic [63:0] diff;
      alpha = pos * ALPHA_STEP;
      beta  = pos * BETA_STEP;
      diff  = (64'(b) + 64'(alpha)) * 64'(cur) - 64'(beta) * 64'(prev);
      return term_type'(diff % 64'(CK_MODULUS));
   endfunction

   function automatic logic diff_negative(data_type b, pos_type pos, term_type cur,
                                          term_type prev);
      pos_type alpha;
      pos_type beta;
      alpha = pos * ALPHA_STEP;
      beta  = pos * BETA_STEP;
      return (64'(b) + 64'(alpha)) * 64'(cur) < 64'(beta) * 64'(prev);
   endfunction

   function automatic void rearm_checksum();
      sum_prev_term = TERM_RESET;
      sum_cur_term  = TERM_RESET;
      sum_position  = '0;
      sum_at_start  = 1'b1;
   endfunction

   // Advance the predictor by one accepted byte
   function automatic void absorb_byte(data_type b, logic last);
      term_type nxt;
      if (sum_at_start) begin
         sum_prev_term = TERM_RESET;
         sum_cur_term  = term_type'(b) + FIRST_OFFSET;
         sum_position  = pos_type'(1);
         sum_at_start  = 1'b0;
      end else begin
         nxt           = next_term(b, sum_position, sum_cur_term, sum_prev_term);
         sum_prev_term = sum_cur_term;
         sum_cur_term  = nxt;
         sum_position  = sum_position + pos_type'(1);
      end
      if (last) begin
         pending_checksums.push_back(sum_cur_term);
         rearm_checksum();
      end
   endfunction

   function automatic data_type pick_byte();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return data_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Check results, then predict from accepted bytes
   always @(posedge clock) begin : monitor
      term_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_checksums.size() == 0) begin
               $display("%0t: checksum %0d with none pending", $time, rsp_checksum_value);
               fail_count++;
            end else begin
               want = pending_checksums.pop_front();
               if (rsp_checksum_value !== want) begin
                  $display("%0t: checksum mismatch, expected %0d, actual %0d",
                           $time, want, rsp_checksum_value);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            absorb_byte(req_data_byte, req_last_byte);
         end
      end
   end

   // Receiver: long hold-off on request, else its own stall pattern
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else if (!stalls_on) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready   <= ready_pattern[pattern_idx];
         pattern_idx <= pattern_idx + 4'd1;
         if (pattern_idx == 4'hF) begin
            ready_pattern <= 16'($urandom) | 16'($urandom);
         end
      end
   end

   // Watchdog on transaction-free cycles
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte and hold it until accepted; gaps fall between bursts
   task automatic send_byte(input data_type b, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   // Idle first so the monitor has logged the last accepted byte
   task automatic wait_for_checksums();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_checksums.size() != 0) @(posedge clock);
   endtask

   task automatic pick_idle_mode();
      gaps_on   = $urandom_range(0, 1);
      stalls_on = $urandom_range(0, 1);
   endtask

   // Single-byte messages give byte + 7
   task automatic test_single_byte_messages();
      send_byte(8'd0, 1'b1);
      send_byte(8'd255, 1'b1);
      send_byte(8'd128, 1'b1);
   endtask

   task automatic test_extreme_bytes();
      repeat (3) send_byte(8'd255, 1'b0);
      send_byte(8'd255, 1'b1);
      repeat (3) send_byte(8'd0, 1'b0);
      send_byte(8'd0, 1'b1);
   endtask

   // Find a three-byte message whose last step has beta*prev above the product
   task automatic test_negative_difference();
      int unsigned b0;
      int unsigned b1;
      data_type    keep0;
      data_type    keep1;
      term_type    cur;
      logic        found;
      found = 1'b0;
      keep0 = '0;
      keep1 = '0;
      for (b0 = 0; b0 < 256; b0++) begin
         for (b1 = 0; b1 < 256; b1++) begin
            cur = next_term(data_type'(b1), pos_type'(1), term_type'(b0) + FIRST_OFFSET,
                            TERM_RESET);
            if (!found && diff_negative('0, pos_type'(2), cur, term_type'(b0) + FIRST_OFFSET))
            begin
               found = 1'b1;
               keep0 = data_type'(b0);
               keep1 = data_type'(b1);
            end
         end
      end
      send_byte(keep0, 1'b0);
      send_byte(keep1, 1'b0);
      send_byte('0, 1'b1);
   endtask

   // Receiver holds off while short messages keep coming, so the input stalls
   task automatic test_output_hold_off();
      int unsigned k;
      gaps_on       = 1'b0;
      hold_off_left = 80;
      for (k = 0; k < 6; k++) begin
         if (k[0]) begin
            send_byte(pick_byte(), 1'b0);
         end
         send_byte(pick_byte(), 1'b1);
      end
   endtask

   // Position counter wraps past 256
   task automatic test_long_message();
      int unsigned len;
      int unsigned k;
      pick_idle_mode();
      len = $urandom_range(257, 290);
      for (k = 0; k < len; k++) begin
         send_byte(pick_byte(), k == len - 1);
      end
   endtask

   task automatic test_random_messages(input int unsigned item_goal);
      int unsigned sent;
      int unsigned len;
      int unsigned k;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(0, 7) == 0) begin
            pick_idle_mode();
         end
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         for (k = 0; k < len; k++) begin
            send_byte(pick_byte(), k == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      rearm_checksum();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_byte_messages();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      test_extreme_bytes();
      test_negative_difference();
      wait_for_checksums();
      test_output_hold_off();
      wait_for_checksums();
      test_long_message();
      test_random_messages(170);

      wait_for_checksums();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_checksums.size() != 0) begin
         $display("%0t: %0d checksums never arrived", $time, pending_checksums.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
